// ===== hdl/dmvw_pkg.sv =====
// ----------------------------------------------------------------------------
// Dark mask package
// Shared widths, constants and register indexes of the variance-weighted
// dark mask block.
// ----------------------------------------------------------------------------
package dmvw_pkg;

  // Field widths
  localparam int PIX_W          = 16;
  localparam int PIXEL_BITS_DEF = 16;
  localparam int THR_W          = 16;
  localparam int TRW_W          = 20;
  localparam int MASK_W         = 17;
  localparam int WN_W           = 20;

  // Configuration port
  localparam int CFG_AW = 8;
  localparam int CFG_DW = 32;

  typedef enum logic [CFG_AW-1:0] {
    CFG_DARK_THRESHOLD   = 8'd0,
    CFG_TRANSITION_WIDTH = 8'd1
  } cfg_idx_e;

  // Register reset values
  localparam logic [THR_W-1:0] THR_RST = 16'd4096;
  localparam logic [TRW_W-1:0] TRW_RST = 20'd13107;

  // Arithmetic constants (variance weight full scale is 81 * 10000)
  localparam int unsigned VAR_FULL  = 810000;
  localparam int unsigned BAND_BASE = 3240000;   // 4 * VAR_FULL
  localparam int unsigned BAND_DIV  = 4050000;   // 5 * VAR_FULL
  localparam int unsigned DEEP_BASE = 13770000;  // 17 * VAR_FULL
  localparam int unsigned DEEP_DIV  = 16200000;  // 20 * VAR_FULL
  localparam int unsigned SMOOTH_K  = 196608;    // 3.0 in Q16
  localparam logic [MASK_W-1:0] MASK_ONE = 17'h10000;

endpackage

// ===== hdl/dmvw_if.sv =====
// ----------------------------------------------------------------------------
// Dark mask channel interfaces
// Valid/ready channels for pixel windows, mask results and register writes.
// ----------------------------------------------------------------------------
interface dmvw_pix_if;
  logic                        valid;
  logic                        ready;
  logic [dmvw_pkg::PIX_W-1:0]  pix_nw;
  logic [dmvw_pkg::PIX_W-1:0]  pix_n;
  logic [dmvw_pkg::PIX_W-1:0]  pix_ne;
  logic [dmvw_pkg::PIX_W-1:0]  pix_w;
  logic [dmvw_pkg::PIX_W-1:0]  pix_center;
  logic [dmvw_pkg::PIX_W-1:0]  pix_e;
  logic [dmvw_pkg::PIX_W-1:0]  pix_sw;
  logic [dmvw_pkg::PIX_W-1:0]  pix_s;
  logic [dmvw_pkg::PIX_W-1:0]  pix_se;
  logic                        window_inside;

  modport source (output valid, pix_nw, pix_n, pix_ne, pix_w, pix_center, pix_e,
                  pix_sw, pix_s, pix_se, window_inside, input ready);
  modport sink   (input valid, pix_nw, pix_n, pix_ne, pix_w, pix_center, pix_e,
                  pix_sw, pix_s, pix_se, window_inside, output ready);
endinterface

interface dmvw_mask_if;
  logic                        valid;
  logic                        ready;
  logic [dmvw_pkg::MASK_W-1:0] mask_value;
  logic                        is_dark;

  modport source (output valid, mask_value, is_dark, input ready);
  modport sink   (input valid, mask_value, is_dark, output ready);
endinterface

interface dmvw_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [dmvw_pkg::CFG_AW-1:0] addr;
  logic [dmvw_pkg::CFG_DW-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ===== hdl/dark_mask_variance_weighted_unit.sv =====
// ----------------------------------------------------------------------------
// Variance-weighted dark mask unit
// Per-pixel dark mask from a 3x3 window, weighted by the window variance.
// ----------------------------------------------------------------------------
// The unit takes one window per clock unless its exit is blocked and returns
// one mask result per window, in order. An item passes 41 register stages:
// the capture stage, a 17-stage divider for the smoothstep ratio, five
// multiply and operand stages, a second 17-stage divider shared by the
// transition and deep ramps, and the output register. The capture stage
// loads at the window transaction edge. Nine square lanes feed a four-stage
// variance merge that runs beside the first divider. Input transactions are
// taken unless the last stage holds an item while a result waits unaccepted
// in the output register. Configuration writes are taken at any time and
// must only be issued while the unit is idle.
module dark_mask_variance_weighted_unit #(
  parameter int PIXEL_BITS = dmvw_pkg::PIXEL_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  dmvw_pix_if.sink           pix_i,
  dmvw_mask_if.source        mask_o,
  dmvw_cfg_if.sink           cfg_i
);

  localparam int MW      = dmvw_pkg::MASK_W;
  localparam int TRW     = dmvw_pkg::TRW_W;
  localparam int THW     = dmvw_pkg::THR_W;
  localparam int FN_W    = TRW + MW;
  localparam int ND_W    = 23;
  localparam int WB_W    = 22;
  localparam int WD_W    = 24;
  localparam int PR_W    = ND_W + WD_W;
  localparam int F2_W    = 2 * MW;
  localparam int G_W     = 18;
  localparam int PD_W    = F2_W + G_W;
  localparam int TN_W    = MW + WB_W;
  localparam int NUM_W   = PR_W + MW;

  // Pipeline stage numbers
  localparam int ST_WN   = 5;
  localparam int ST_WT   = ST_WN + 1;
  localparam int ST_F16  = 1 + MW;
  localparam int ST_SQ   = ST_F16 + 1;
  localparam int ST_PROD = ST_F16 + 2;
  localparam int ST_S16  = ST_F16 + 3;
  localparam int ST_SEL  = ST_F16 + 4;
  localparam int ST_RND  = ST_F16 + 5;
  localparam int NS      = ST_RND + MW;

  localparam logic [THW-1:0] PMASK = THW'((17'd1 << PIXEL_BITS) - 17'd1);

  typedef struct packed {
    logic lt;
    logic band;
  } flag_t;

  typedef struct packed {
    logic [ND_W-1:0] nf;
    logic [ND_W-1:0] df;
  } deep_t;

  typedef struct packed {
    logic [WB_W-1:0] wb;
    logic [WD_W-1:0] wd;
  } wt_t;

  logic [THW-1:0] thr_q;
  logic [TRW-1:0] trw_q;

  logic           adv;
  logic [NS:1]    vld_q;
  logic           out_vld_q;
  logic [MW-1:0]  out_mask_q;
  logic           out_dark_q;

  logic [8:0][dmvw_pkg::PIX_W-1:0]   pix_all;
  logic [8:0][PIXEL_BITS-1:0]        lane_v;
  logic [8:0][2*PIXEL_BITS-1:0]      lane_sq;
  logic [dmvw_pkg::WN_W-1:0]         wn;

  // Stage-one capture
  logic [THW-1:0]  p_in;
  logic [TRW:0]    p16_sum, t16;
  logic [TRW-1:0]  a_in;
  logic [TRW:0]    d_in;
  flag_t           flag_in;
  logic [THW-1:0]  p1_q;
  logic [TRW-1:0]  d1_q;
  logic [FN_W-1:0] fn1_q;
  logic [TRW-1:0]  fd1_q;
  logic            ins1_q;

  flag_t           flag_q [1:NS];
  deep_t           deep_q [2:ST_PROD];
  wt_t             wt_q   [ST_WT:ST_S16];
  deep_t           deep_in;
  wt_t             wt_in;

  logic [MW-1:0]     f16;
  logic [F2_W-1:0]   f2_q;
  logic [G_W-1:0]    g_q;
  logic [PD_W-1:0]   prod_q;
  logic [PD_W:0]     prod_rnd;
  logic [MW-1:0]     s16_q;
  logic [PR_W-1:0]   dnum_q, dden_q;
  logic [NUM_W-1:0]  num_q;
  logic [PR_W-1:0]   den_q;
  logic [NUM_W-1:0]  rn_q;
  logic [PR_W-1:0]   rd_q;
  logic [MW-1:0]     quo;
  logic [TN_W-1:0]   tnum;

  // Configuration registers; unknown indexes are ignored.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= dmvw_pkg::THR_RST;
      trw_q <= dmvw_pkg::TRW_RST;
    end else if (cfg_i.valid) begin
      case (dmvw_pkg::cfg_idx_e'(cfg_i.addr))
        dmvw_pkg::CFG_DARK_THRESHOLD:   thr_q <= cfg_i.data[THW-1:0];
        dmvw_pkg::CFG_TRANSITION_WIDTH: trw_q <= cfg_i.data[TRW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advances unless a finished result is blocked at the exit.
  assign adv         = !vld_q[NS] || !out_vld_q || mask_o.ready;
  assign pix_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        vld_q <= {vld_q[NS-1:1], pix_i.valid};
      end
      if (adv && vld_q[NS]) begin
        out_vld_q <= 1'b1;
      end else if (mask_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Square lanes, one per window pixel.
  assign pix_all[0] = pix_i.pix_nw;
  assign pix_all[1] = pix_i.pix_n;
  assign pix_all[2] = pix_i.pix_ne;
  assign pix_all[3] = pix_i.pix_w;
  assign pix_all[4] = pix_i.pix_center;
  assign pix_all[5] = pix_i.pix_e;
  assign pix_all[6] = pix_i.pix_sw;
  assign pix_all[7] = pix_i.pix_s;
  assign pix_all[8] = pix_i.pix_se;

  for (genvar i = 0; i < 9; i++) begin : g_lane
    dmvw_sq_lane #(.PIXEL_BITS(PIXEL_BITS)) u_lane (
      .clk_i (clk_i),
      .en_i  (adv),
      .pix_i (pix_all[i]),
      .v_o   (lane_v[i]),
      .sq_o  (lane_sq[i])
    );
  end

  dmvw_var_merge #(.PIXEL_BITS(PIXEL_BITS)) u_merge (
    .clk_i    (clk_i),
    .en_i     (adv),
    .inside_i (ins1_q),
    .v_i      (lane_v),
    .sq_i     (lane_sq),
    .wn_o     (wn)
  );

  // Threshold tests and smoothstep dividend for the incoming window.
  assign p_in         = pix_i.pix_center & PMASK;
  assign p16_sum      = {1'b0, p_in, 4'b0} + {1'b0, trw_q};
  assign t16          = {1'b0, thr_q, 4'b0};
  assign a_in         = {thr_q - p_in, 4'b0};
  assign d_in         = t16 - {1'b0, trw_q};
  assign flag_in.lt   = p_in < thr_q;
  assign flag_in.band = (p_in < thr_q) && (p16_sum > t16);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q   <= p_in;
      d1_q   <= d_in[TRW-1:0];
      fn1_q  <= FN_W'({a_in, 16'b0}) + FN_W'(trw_q >> 1);
      fd1_q  <= trw_q;
      ins1_q <= pix_i.window_inside;
    end
  end

  // Deep ramp factors; an empty deep span falls back to three fifths.
  always_comb begin
    if (d1_q == '0) begin
      deep_in.nf = ND_W'(3);
      deep_in.df = ND_W'(5);
    end else begin
      deep_in.nf = ND_W'(d1_q) + (ND_W'(d1_q) << 1) + (ND_W'(p1_q) << 5);
      deep_in.df = (ND_W'(d1_q) << 2) + ND_W'(d1_q);
    end
  end

  // Variance factors of both ramps.
  assign wt_in.wb = WB_W'(dmvw_pkg::BAND_BASE) + WB_W'(wn);
  assign wt_in.wd = WD_W'(dmvw_pkg::DEEP_BASE) + WD_W'(wn) + (WD_W'(wn) << 1);

  // Side data riding along with each item.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      flag_q[1] <= flag_in;
      for (int k = 2; k <= NS; k++) begin
        flag_q[k] <= flag_q[k-1];
      end
      deep_q[2] <= deep_in;
      for (int k = 3; k <= ST_PROD; k++) begin
        deep_q[k] <= deep_q[k-1];
      end
      wt_q[ST_WT] <= wt_in;
      for (int k = ST_WT + 1; k <= ST_S16; k++) begin
        wt_q[k] <= wt_q[k-1];
      end
    end
  end

  // Smoothstep ratio 16*(T-P)/R in Q16.
  dmvw_div #(.DW(TRW), .QW(MW)) u_div_ratio (
    .clk_i (clk_i),
    .en_i  (adv),
    .n_i   (fn1_q),
    .d_i   (fd1_q),
    .q_o   (f16)
  );

  // Smoothstep polynomial f*f*(3 - 2f), then rounding back to Q16.
  assign prod_rnd = {1'b0, prod_q} + (PD_W + 1)'(64'h8000_0000);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f2_q   <= F2_W'(f16) * F2_W'(f16);
      g_q    <= G_W'(dmvw_pkg::SMOOTH_K) - (G_W'(f16) << 1);
      prod_q <= PD_W'(f2_q) * PD_W'(g_q);
      s16_q  <= prod_rnd[32 +: MW];
      dnum_q <= PR_W'(deep_q[ST_PROD].nf) * PR_W'(wt_q[ST_PROD].wd);
      dden_q <= PR_W'(deep_q[ST_PROD].df) * PR_W'(dmvw_pkg::DEEP_DIV);
    end
  end

  // Operand select for the shared final divider, then half-divisor rounding.
  assign tnum = TN_W'(s16_q) * TN_W'(wt_q[ST_S16].wb);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (flag_q[ST_S16].band) begin
        num_q <= NUM_W'(tnum);
        den_q <= PR_W'(dmvw_pkg::BAND_DIV);
      end else begin
        num_q <= NUM_W'({dnum_q, 16'b0});
        den_q <= dden_q;
      end
      rn_q <= num_q + NUM_W'(den_q >> 1);
      rd_q <= den_q;
    end
  end

  dmvw_div #(.DW(PR_W), .QW(MW)) u_div_mask (
    .clk_i (clk_i),
    .en_i  (adv),
    .n_i   (rn_q),
    .d_i   (rd_q),
    .q_o   (quo)
  );

  // Output register with clamp; bright pixels get no mask.
  always_ff @(posedge clk_i) begin
    if (adv && vld_q[NS]) begin
      out_dark_q <= flag_q[NS].lt;
      if (!flag_q[NS].lt) begin
        out_mask_q <= '0;
      end else if (quo > dmvw_pkg::MASK_ONE) begin
        out_mask_q <= dmvw_pkg::MASK_ONE;
      end else begin
        out_mask_q <= quo;
      end
    end
  end

  assign mask_o.valid      = out_vld_q;
  assign mask_o.mask_value = out_mask_q;
  assign mask_o.is_dark    = out_dark_q;

  // Checks
  a_mask_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mask_o.valid |-> (mask_o.mask_value <= dmvw_pkg::MASK_ONE))
    else $error("mask value above one");

  a_bright_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mask_o.valid && !mask_o.is_dark) |-> (mask_o.mask_value == '0))
    else $error("bright pixel with nonzero mask");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NS] && out_vld_q && !mask_o.ready) |-> !pix_i.ready)
    else $error("input taken while pipeline exit is blocked");

  a_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |=> vld_q[1])
    else $error("accepted transaction not captured");

endmodule

// ===== hdl/dmvw_sq_lane.sv =====
// ----------------------------------------------------------------------------
// Dark mask square lane
// One window pixel: trims it to the pixel width and registers it with its
// square.
// ----------------------------------------------------------------------------
module dmvw_sq_lane #(
  parameter int PIXEL_BITS = dmvw_pkg::PIXEL_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [dmvw_pkg::PIX_W-1:0] pix_i,
  output logic [PIXEL_BITS-1:0]      v_o,
  output logic [2*PIXEL_BITS-1:0]    sq_o
);

  localparam int SQW = 2 * PIXEL_BITS;

  logic [PIXEL_BITS-1:0] v_q;
  logic [SQW-1:0]        sq_q;

  // Pixel and its square, one multiplier per lane.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q  <= pix_i[PIXEL_BITS-1:0];
      sq_q <= SQW'(pix_i[PIXEL_BITS-1:0]) * SQW'(pix_i[PIXEL_BITS-1:0]);
    end
  end

  assign v_o  = v_q;
  assign sq_o = sq_q;

endmodule

// ===== hdl/dmvw_var_merge.sv =====
// ----------------------------------------------------------------------------
// Dark mask variance merge
// Combines the nine lanes into sums, forms 81 times the variance and clamps
// it to the full-scale weight; border windows get zero. Four register stages.
// ----------------------------------------------------------------------------
module dmvw_var_merge #(
  parameter int PIXEL_BITS = dmvw_pkg::PIXEL_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic                                inside_i,
  input  logic [8:0][PIXEL_BITS-1:0]          v_i,
  input  logic [8:0][2*PIXEL_BITS-1:0]        sq_i,
  output logic [dmvw_pkg::WN_W-1:0]           wn_o
);

  localparam int S3W = PIXEL_BITS + 2;
  localparam int Q3W = 2 * PIXEL_BITS + 2;
  localparam int SW  = PIXEL_BITS + 4;
  localparam int QSW = 2 * PIXEL_BITS + 4;
  localparam int VW  = 2 * PIXEL_BITS + 8;

  logic [2:0][S3W-1:0] s3_q;
  logic [2:0][Q3W-1:0] q3_q;
  logic [SW-1:0]       s_q;
  logic [QSW-1:0]      q_q;
  logic [VW-1:0]       s2_q;
  logic [VW-1:0]       q9_q;
  logic                ins_a_q, ins_b_q, ins_c_q;
  logic [dmvw_pkg::WN_W-1:0] wn_q;
  logic [VW-1:0]       v9;

  // First level: three partial sums of three lanes each.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int g = 0; g < 3; g++) begin
        s3_q[g] <= S3W'(v_i[3*g]) + S3W'(v_i[3*g+1]) + S3W'(v_i[3*g+2]);
        q3_q[g] <= Q3W'(sq_i[3*g]) + Q3W'(sq_i[3*g+1]) + Q3W'(sq_i[3*g+2]);
      end
      ins_a_q <= inside_i;
    end
  end

  // Second level: full sum and sum of squares.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q     <= SW'(s3_q[0]) + SW'(s3_q[1]) + SW'(s3_q[2]);
      q_q     <= QSW'(q3_q[0]) + QSW'(q3_q[1]) + QSW'(q3_q[2]);
      ins_b_q <= ins_a_q;
    end
  end

  // Square of the sum and nine times the sum of squares.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q    <= VW'(s_q) * VW'(s_q);
      q9_q    <= (VW'(q_q) << 3) + VW'(q_q);
      ins_c_q <= ins_b_q;
    end
  end

  // Variance times 81, clamped; border windows get no weight.
  assign v9 = q9_q - s2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!ins_c_q) begin
        wn_q <= '0;
      end else if (v9 > VW'(dmvw_pkg::VAR_FULL)) begin
        wn_q <= dmvw_pkg::WN_W'(dmvw_pkg::VAR_FULL);
      end else begin
        wn_q <= v9[dmvw_pkg::WN_W-1:0];
      end
    end
  end

  assign wn_o = wn_q;

endmodule

// ===== hdl/dmvw_div.sv =====
// ----------------------------------------------------------------------------
// Dark mask pipelined divider
// Restoring division, one quotient bit per register stage. The caller keeps
// the quotient below 2^QW, so the upper dividend part is below the divisor.
// ----------------------------------------------------------------------------
module dmvw_div #(
  parameter int DW = dmvw_pkg::TRW_W,
  parameter int QW = dmvw_pkg::MASK_W
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [DW+QW-1:0]   n_i,
  input  logic [DW-1:0]      d_i,
  output logic [QW-1:0]      q_o
);

  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] r_in, d_in;
    logic [QW-1:0] l_in, q_in;
    logic [DW:0]   cat, diff;

    // Stage inputs come from the port or from the previous stage.
    if (k == 0) begin : g_first
      assign r_in = n_i[DW+QW-1:QW];
      assign d_in = d_i;
      assign l_in = n_i[QW-1:0];
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign d_in = den_q[k-1];
      assign l_in = low_q[k-1];
      assign q_in = quo_q[k-1];
    end

    // Trial subtract of the divisor from the shifted partial remainder.
    assign cat  = {r_in, l_in[QW-1]};
    assign diff = cat - {1'b0, d_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= diff[DW] ? cat[DW-1:0] : diff[DW-1:0];
        den_q[k] <= d_in;
        low_q[k] <= l_in << 1;
        quo_q[k] <= {q_in[QW-2:0], ~diff[DW]};
      end
    end
  end

  assign q_o = quo_q[QW-1];

endmodule
